@@ hw/rtl/mos_pkg.sv @@
package mos_pkg;

	// default store depth, legal range 1 to 16
	localparam int MAX_ACCOUNTS_DEF = 16;

	localparam int CMD_W   = 2;
	localparam int VALUE_W = 32;
	localparam int MASK_W  = 16;
	localparam int CNT_W   = 5;
	localparam int TOTAL_W = 36;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_SOLVE = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

endpackage

@@ hw/rtl/mos_in_if.sv @@
interface mos_in_if;
	import mos_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [VALUE_W-1:0] account_value;
	logic [VALUE_W-1:0] target;

	modport source (output valid, output cmd, output account_value, output target,
		input ready);
	modport sink (input valid, input cmd, input account_value, input target,
		output ready);

endinterface

@@ hw/rtl/mos_out_if.sv @@
interface mos_out_if;
	import mos_pkg::*;

	logic               valid;
	logic               ready;
	logic               found;
	logic [MASK_W-1:0]  chosen_mask;
	logic [CNT_W-1:0]   chosen_count;
	logic [TOTAL_W-1:0] paid_total;
	logic [TOTAL_W-1:0] overpay;

	modport source (output valid, output found, output chosen_mask, output chosen_count,
		output paid_total, output overpay, input ready);
	modport sink (input valid, input found, input chosen_mask, input chosen_count,
		input paid_total, input overpay, output ready);

endinterface

@@ hw/rtl/mos_ram.sv @@
module mos_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/min_overpay_subset_sum_core.sv @@
// Minimum-overpay subset sum engine.
//
// req (sink): one transfer per command. cmd LOAD appends account_value to the
// account store (ignored once MAX_ACCOUNTS entries are held), CLEAR empties the
// store, SOLVE searches for the subset whose sum covers target with the least
// overpay. Unused codes are dropped. Only SOLVE produces a transfer on rsp.
//
// LOAD and CLEAR complete in the idle state. SOLVE first builds a table of
// per-step sum deltas from the n loaded amounts, then searches the subsets in
// order, at most 2^n - 1 of them, ending early on an exact match, or skips
// the search when the sum of all amounts is below target. Each subset reads
// one delta from the delta RAM (indexed by the trailing zero count of the
// subset number) and adds it to the running sum in a single adder.
//
// req.ready is high only while the engine is idle. A held rsp result does not
// block loads, and a new SOLVE runs its search while the old result waits; it
// then holds in the finish state until rsp drains.
//
// Reset clears the account count, the control state and rsp.valid. The RAM
// contents are not cleared; only entries that were loaded are ever used.
module min_overpay_subset_sum_core #(
	parameter int MAX_ACCOUNTS = mos_pkg::MAX_ACCOUNTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	mos_in_if.sink    req,
	mos_out_if.source rsp
);
	import mos_pkg::*;

	localparam int AW = (MAX_ACCOUNTS > 1) ? $clog2(MAX_ACCOUNTS) : 1;
	localparam int CW = $clog2(MAX_ACCOUNTS + 1);
	localparam int SW = VALUE_W + CW;      // exact width of any subset sum
	localparam int DW = SW + 1;            // signed delta width

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [CW-1:0]           count_q;
	logic [CW-1:0]           k_q;
	logic                    pv_s1;
	logic [MAX_ACCOUNTS-1:0] iss_q;
	logic                    iss_v_q;
	logic                    v_s1;
	logic                    found_q;

	logic                    rsp_valid_q;
	logic                    rsp_found_q;
	logic [MASK_W-1:0]       rsp_mask_q;
	logic [CNT_W-1:0]        rsp_count_q;
	logic [TOTAL_W-1:0]      rsp_paid_q;
	logic [TOTAL_W-1:0]      rsp_over_q;

	// datapath registers
	logic [CW-1:0]           n_q;
	logic [VALUE_W-1:0]      target_q;
	logic [MAX_ACCOUNTS-1:0] last_q;
	logic [SW-1:0]           suffix_q;
	logic [AW-1:0]           pk_s1;
	logic [MAX_ACCOUNTS-1:0] sub_s1;
	logic [AW-1:0]           tz_s1;
	logic [SW-1:0]           sum_q;
	logic [CW-1:0]           cnt_q;
	logic [SW-1:0]           best_q;
	logic [MAX_ACCOUNTS-1:0] ch_i_q;
	logic [CW-1:0]           ch_cnt_q;
	logic [SW-1:0]           ch_sum_q;

	logic                    req_xfer;
	logic                    acct_we;
	logic [AW-1:0]           acct_raddr;
	logic [VALUE_W-1:0]      acct_rdata;
	logic [DW-1:0]           delta_wdata;
	logic [DW-1:0]           delta_rdata;
	logic [AW-1:0]           tz_w;
	logic [MAX_ACCOUNTS:0]   last_full_w;
	logic [DW-1:0]           s_full_w;
	logic [SW-1:0]           s_w;
	logic [SW-1:0]           tgt_w;
	logic [CW-1:0]           cnt_next_w;
	logic                    hit_w;
	logic                    stop_w;
	logic                    prep_done_w;
	logic [MASK_W-1:0]       mask_w;

	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;

	assign acct_we = req_xfer && (req.cmd == CMD_LOAD) && (count_q < CW'(MAX_ACCOUNTS));

	// account j is visited in prep step k = n-1-j
	assign acct_raddr  = AW'(n_q - CW'(1) - k_q);
	assign delta_wdata = DW'(acct_rdata) - DW'(suffix_q);
	assign prep_done_w = (k_q == n_q) && !pv_s1;

	// all ones over the low n bits: the last subset number
	assign last_full_w = ((MAX_ACCOUNTS + 1)'(1) << count_q) - (MAX_ACCOUNTS + 1)'(1);

	// trailing zero count of the subset number about to issue
	always_comb begin
		tz_w = '0;
		for (int b = MAX_ACCOUNTS - 1; b >= 0; b--) begin
			if (iss_q[b]) begin
				tz_w = AW'(b);
			end
		end
	end

	// going from i-1 to i clears tz trailing bits and sets one
	assign s_full_w   = DW'(sum_q) + delta_rdata;
	assign s_w        = SW'(s_full_w);
	assign tgt_w      = SW'(target_q);
	assign cnt_next_w = CW'(cnt_q + CW'(1) - CW'(tz_s1));
	assign hit_w      = v_s1 && (s_w <= best_q) && (s_w >= tgt_w);
	assign stop_w     = v_s1 && ((hit_w && (s_w == tgt_w)) || (sub_s1 == last_q));

	// chosen mask: account j sits at bit n-1-j of the subset number
	always_comb begin
		mask_w = '0;
		for (int j = 0; j < MASK_W; j++) begin
			if (j < MAX_ACCOUNTS && found_q) begin
				if (CW'(j) < n_q) begin
					mask_w[j] = ch_i_q[AW'(n_q - CW'(1) - CW'(j))];
				end
			end
		end
	end

	mos_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ACCOUNTS)) u_acct_ram (
		.clk   (clk),
		.we    (acct_we),
		.waddr (AW'(count_q)),
		.wdata (req.account_value),
		.raddr (acct_raddr),
		.rdata (acct_rdata)
	);

	mos_ram #(.WIDTH(DW), .DEPTH(MAX_ACCOUNTS)) u_delta_ram (
		.clk   (clk),
		.we    (pv_s1),
		.waddr (pk_s1),
		.wdata (delta_wdata),
		.raddr (tz_w),
		.rdata (delta_rdata)
	);

	// control state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			pv_s1       <= 1'b0;
			iss_q       <= '0;
			iss_v_q     <= 1'b0;
			v_s1        <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_found_q <= 1'b0;
			rsp_mask_q  <= '0;
			rsp_count_q <= '0;
			rsp_paid_q  <= '0;
			rsp_over_q  <= '0;
		end else begin
			// the finish state reloads the slot itself
			if (rsp_valid_q && rsp.ready && state_q != ST_FINISH) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						unique case (req.cmd)
							CMD_LOAD: begin
								if (acct_we) begin
									count_q <= count_q + CW'(1);
								end
							end
							CMD_CLEAR: begin
								count_q <= '0;
							end
							CMD_SOLVE: begin
								found_q <= 1'b0;
								k_q     <= '0;
								pv_s1   <= 1'b0;
								// empty store: not found, even for a zero target
								state_q <= (count_q == '0) ? ST_FINISH : ST_PREP;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PREP: begin
					if (k_q < n_q) begin
						k_q   <= k_q + CW'(1);
						pv_s1 <= 1'b1;
					end else begin
						pv_s1 <= 1'b0;
					end
					if (prep_done_w) begin
						if (suffix_q >= tgt_w) begin
							iss_q   <= MAX_ACCOUNTS'(1);
							iss_v_q <= 1'b1;
							v_s1    <= 1'b0;
							state_q <= ST_SEARCH;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SEARCH: begin
					if (hit_w) begin
						found_q <= 1'b1;
					end
					if (stop_w) begin
						iss_v_q <= 1'b0;
						v_s1    <= 1'b0;
						state_q <= ST_FINISH;
					end else begin
						v_s1 <= iss_v_q;
						if (iss_v_q) begin
							if (iss_q == last_q) begin
								iss_v_q <= 1'b0;
							end else begin
								iss_q <= iss_q + MAX_ACCOUNTS'(1);
							end
						end
					end
				end
				ST_FINISH: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_found_q <= found_q;
						rsp_mask_q  <= mask_w;
						rsp_count_q <= found_q ? CNT_W'(ch_cnt_q) : '0;
						rsp_paid_q  <= found_q ? TOTAL_W'(ch_sum_q) : '0;
						rsp_over_q  <= found_q ? TOTAL_W'(ch_sum_q) - TOTAL_W'(target_q) : '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (req_xfer && req.cmd == CMD_SOLVE) begin
			n_q      <= count_q;
			target_q <= req.target;
			last_q   <= MAX_ACCOUNTS'(last_full_w);
			suffix_q <= '0;
		end
		if (state_q == ST_PREP) begin
			pk_s1 <= AW'(k_q);
			if (pv_s1) begin
				suffix_q <= suffix_q + SW'(acct_rdata);
			end
			if (prep_done_w) begin
				sum_q  <= '0;
				cnt_q  <= '0;
				best_q <= suffix_q;
			end
		end
		if (state_q == ST_SEARCH) begin
			sub_s1 <= iss_q;
			tz_s1  <= tz_w;
			if (v_s1) begin
				sum_q <= s_w;
				cnt_q <= cnt_next_w;
				if (hit_w) begin
					ch_i_q   <= sub_s1;
					ch_cnt_q <= cnt_next_w;
					ch_sum_q <= s_w;
				end
				if ((s_w > tgt_w) && (s_w < best_q)) begin
					best_q <= s_w;
				end
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.found        = rsp_found_q;
	assign rsp.chosen_mask  = rsp_mask_q;
	assign rsp.chosen_count = rsp_count_q;
	assign rsp.paid_total   = rsp_paid_q;
	assign rsp.overpay      = rsp_over_q;

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ACCOUNTS))
		else $error("account count beyond store depth");

	a_tz_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH && v_s1) |-> (CW'(tz_s1) < n_q))
		else $error("delta index beyond loaded accounts");

	a_chosen_le_best: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH && found_q) |-> (ch_sum_q <= best_q))
		else $error("chosen sum above bound");

	a_solve_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_xfer && req.cmd == CMD_SOLVE) |=> (state_q != ST_IDLE))
		else $error("solve transfer did not start a search");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_found_q) |->
			(rsp_mask_q == '0 && rsp_count_q == '0 && rsp_paid_q == '0 && rsp_over_q == '0))
		else $error("not found result carries data");

endmodule
